// ===== rtl/disk_noise_sample_player_top_assert.svh =====
// Assertion macros shared by the drive-noise sample player RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef DISK_NOISE_SAMPLE_PLAYER_TOP_ASSERT_SVH
`define DISK_NOISE_SAMPLE_PLAYER_TOP_ASSERT_SVH

// Checked only outside reset.
`define DNSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define DNSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dnsp_pkg.sv =====
// Shared types and constants of the drive-noise sample player.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dnsp_pkg;

  localparam int MEM_AW     = 16;
  localparam int MEM_WORDS  = 1 << MEM_AW;
  localparam int SEEK_SLOTS = 9;
  localparam int SLOT_W     = 4;
  localparam int SLOT_WEIGHT_BASE = 10;
  localparam int TOTAL_W    = 6;
  localparam int RND_W      = 15;
  localparam int LEN_W      = 17;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int OP_W       = 4;

  localparam logic [15:0] GAIN_MAX   = 16'd32768;
  localparam logic [15:0] GAIN_RESET = 16'd6554;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_EVENT = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_SLOT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_LOOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_UP_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_UP_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_START     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_GAIN     = 3'd6;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH    = 4'd1;
  localparam logic [OP_W-1:0] OP_RD_A     = 4'd2;
  localparam logic [OP_W-1:0] OP_RD_S     = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL_S    = 4'd4;
  localparam logic [OP_W-1:0] OP_ACC      = 4'd5;
  localparam logic [OP_W-1:0] OP_TICK_END = 4'd6;
  localparam logic [OP_W-1:0] OP_WRITE    = 4'd7;
  localparam logic [OP_W-1:0] OP_SLOT     = 4'd8;
  localparam logic [OP_W-1:0] OP_EV_START = 4'd9;
  localparam logic [OP_W-1:0] OP_EV_SUM   = 4'd10;
  localparam logic [OP_W-1:0] OP_DIV      = 4'd11;
  localparam logic [OP_W-1:0] OP_PICK     = 4'd12;
  localparam logic [OP_W-1:0] OP_APPLY    = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/dnsp_datapath.sv =====
// Datapath of the drive-noise sample player: registers, sample memory, mixer and seek pick.
// Depends on dnsp_pkg; driven by dnsp_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module dnsp_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dnsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dnsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [15:0]                      address,
  input  logic signed [15:0]               word_value,
  input  logic [3:0]                       slot_index,
  input  logic [16:0]                      slot_length,
  input  logic [14:0]                      random_value,
  input  dnsp_pkg::dp_cmd_t                dp_cmd,
  output dnsp_pkg::dp_status_t             dp_status,
  output logic signed [16:0]               sample_out
);
  import dnsp_pkg::*;

  // Configuration registers.
  logic              noise_enable;
  logic              spin_loop;
  logic [15:0]       spin_up_start;
  logic [LEN_W-1:0]  spin_up_length;
  logic [15:0]       spin_start;
  logic [LEN_W-1:0]  spin_length;
  logic [15:0]       voice_gain;

  // Voice state.
  logic [15:0]       slot_start [SEEK_SLOTS];
  logic [LEN_W-1:0]  slot_len [SEEK_SLOTS];
  logic [LEN_W-1:0]  up_pos;
  logic [LEN_W-1:0]  spin_pos;
  logic [15:0]       cur_start;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  seek_pos;

  // Seek pick working registers.
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] sum;
  logic               found;
  logic [15:0]        chosen_start;
  logic [LEN_W-1:0]   chosen_len;

  // Latched item and arithmetic pipeline.
  logic [15:0]        lat_address;
  logic [15:0]        lat_word;
  logic [3:0]         lat_slot;
  logic [LEN_W-1:0]   lat_slot_len;
  logic [RND_W-1:0]   rnd_sh;
  logic [15:0]        mem [MEM_WORDS];
  logic signed [15:0] rdata;
  logic signed [31:0] prod;
  logic signed [31:0] acc;

  logic [LEN_W:0]     up_inc;
  logic [LEN_W:0]     sp_inc;
  logic [LEN_W:0]     sk_inc;
  logic               play_up;
  logic               play_spin;
  logic               play_seek;
  logic               spin_done;
  logic [15:0]        gain_sat;
  logic signed [32:0] mul_full;
  logic [MEM_AW-1:0]  addr_a;
  logic [MEM_AW-1:0]  addr_s;
  logic [TOTAL_W-1:0] weight;
  logic [TOTAL_W:0]   rem_sh;
  logic               rem_ge;
  logic [TOTAL_W-1:0] sum_next;
  logic [LEN_W-1:0]   spin_pos_next;
  logic [LEN_W-1:0]   seek_pos_next;

  assign up_inc    = {1'b0, up_pos} + 18'd1;
  assign sp_inc    = {1'b0, spin_pos} + 18'd1;
  assign sk_inc    = {1'b0, seek_pos} + 18'd1;
  assign play_up   = noise_enable && (spin_up_length != '0) && (up_inc < {1'b0, spin_up_length});
  assign play_spin = noise_enable && !play_up && (spin_length != '0) &&
                     ((sp_inc < {1'b0, spin_length}) || spin_loop);
  assign play_seek = noise_enable && (cur_len != '0) && (sk_inc < {1'b0, cur_len});
  assign spin_done = !((spin_length == '0) || (sp_inc < {1'b0, spin_length}));

  assign gain_sat = (voice_gain > GAIN_MAX) ? GAIN_MAX : voice_gain;
  assign mul_full = rdata * $signed({1'b0, gain_sat});

  assign addr_a = play_up ? spin_up_start + up_pos[MEM_AW-1:0]
                          : spin_start + spin_pos[MEM_AW-1:0];
  assign addr_s = cur_start + seek_pos[MEM_AW-1:0];

  assign weight   = TOTAL_W'(SLOT_WEIGHT_BASE) - TOTAL_W'(dp_cmd.idx);
  assign rem_sh   = {rem, rnd_sh[RND_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, total};
  assign sum_next = sum + weight;

  // A looped spin wraps to the start once it runs past its length.
  assign spin_pos_next = (spin_loop && (sp_inc[LEN_W-1:0] >= spin_length)) ? '0
                                                                           : sp_inc[LEN_W-1:0];
  assign seek_pos_next = play_seek ? sk_inc[LEN_W-1:0] : seek_pos;

  assign dp_status.total_zero = (total == '0);

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_WRITE) begin
      mem[lat_address] <= lat_word;
    end
    if (dp_cmd.op == OP_RD_A) begin
      rdata <= $signed(mem[addr_a]);
    end else if (dp_cmd.op == OP_RD_S) begin
      rdata <= $signed(mem[addr_s]);
    end
  end

  // Latched item and mixer pipeline.
  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LATCH: begin
        lat_address  <= address;
        lat_word     <= word_value;
        lat_slot     <= slot_index;
        lat_slot_len <= slot_length;
        rnd_sh       <= random_value;
      end
      OP_RD_S: begin
        prod <= play_up || play_spin ? mul_full[31:0] : '0;
      end
      OP_MUL_S: begin
        acc  <= prod;
        prod <= play_seek ? mul_full[31:0] : '0;
      end
      OP_ACC: begin
        acc <= acc + prod;
      end
      OP_TICK_END: begin
        sample_out <= acc[31:15];
      end
      OP_DIV: begin
        rnd_sh <= {rnd_sh[RND_W-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  // Configuration, voice state and seek pick.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_enable   <= 1'b0;
      spin_loop      <= 1'b0;
      spin_up_start  <= '0;
      spin_up_length <= '0;
      spin_start     <= '0;
      spin_length    <= '0;
      voice_gain     <= GAIN_RESET;
      for (int i = 0; i < SEEK_SLOTS; i++) begin
        slot_start[i] <= '0;
        slot_len[i]   <= '0;
      end
      up_pos       <= '0;
      spin_pos     <= '0;
      cur_start    <= '0;
      cur_len      <= '0;
      seek_pos     <= '0;
      total        <= '0;
      rem          <= '0;
      sum          <= '0;
      found        <= 1'b0;
      chosen_start <= '0;
      chosen_len   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NOISE_ENABLE:   noise_enable   <= cfg_data[0];
          REG_SPIN_LOOP:      spin_loop      <= cfg_data[0];
          REG_SPIN_UP_START:  spin_up_start  <= cfg_data[15:0];
          REG_SPIN_UP_LENGTH: spin_up_length <= cfg_data;
          REG_SPIN_START:     spin_start     <= cfg_data[15:0];
          REG_SPIN_LENGTH:    spin_length    <= cfg_data;
          REG_VOICE_GAIN:     voice_gain     <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      case (dp_cmd.op)
        OP_TICK_END: begin
          if (play_up) begin
            up_pos <= up_inc[LEN_W-1:0];
          end else if (play_spin) begin
            spin_pos <= spin_pos_next;
          end
          if (noise_enable) begin
            seek_pos <= seek_pos_next;
            if ((cur_len != '0) && (seek_pos_next >= cur_len)) begin
              cur_len <= '0;
            end
          end
        end
        OP_SLOT: begin
          if (lat_slot < SLOT_W'(SEEK_SLOTS)) begin
            slot_start[lat_slot] <= lat_address;
            slot_len[lat_slot]   <= lat_slot_len;
          end
        end
        OP_EV_START: begin
          total <= '0;
          rem   <= '0;
          sum   <= '0;
          found <= 1'b0;
          if (noise_enable && !spin_loop && spin_done) begin
            spin_pos <= '0;
          end
        end
        OP_EV_SUM: begin
          if (noise_enable && (slot_len[dp_cmd.idx] != '0)) begin
            total <= total + weight;
          end
        end
        OP_DIV: begin
          rem <= rem_ge ? TOTAL_W'(rem_sh - {1'b0, total}) : rem_sh[TOTAL_W-1:0];
        end
        OP_PICK: begin
          if (slot_len[dp_cmd.idx] != '0) begin
            sum <= sum_next;
            if (!found && (rem < sum_next)) begin
              found        <= 1'b1;
              chosen_start <= slot_start[dp_cmd.idx];
              chosen_len   <= slot_len[dp_cmd.idx];
            end
          end
        end
        OP_APPLY: begin
          if (found && !((cur_len != '0) && (sk_inc < {1'b0, cur_len}))) begin
            cur_start <= chosen_start;
            cur_len   <= chosen_len;
            seek_pos  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dnsp_ctrl.sv =====
// Controller of the drive-noise sample player: sequences each transaction through the datapath.
// Depends on dnsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "disk_noise_sample_player_top_assert.svh"

module dnsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dnsp_pkg::dp_cmd_t    dp_cmd,
  input  dnsp_pkg::dp_status_t dp_status
);
  import dnsp_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_A     = 4'd1;
  localparam logic [3:0] S_RD_S     = 4'd2;
  localparam logic [3:0] S_MUL_S    = 4'd3;
  localparam logic [3:0] S_ACC      = 4'd4;
  localparam logic [3:0] S_OUT      = 4'd5;
  localparam logic [3:0] S_WR       = 4'd6;
  localparam logic [3:0] S_SLOT     = 4'd7;
  localparam logic [3:0] S_EV_START = 4'd8;
  localparam logic [3:0] S_EV_SUM   = 4'd9;
  localparam logic [3:0] S_EV_CHECK = 4'd10;
  localparam logic [3:0] S_EV_DIV   = 4'd11;
  localparam logic [3:0] S_EV_PICK  = 4'd12;
  localparam logic [3:0] S_EV_APPLY = 4'd13;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;
  logic             out_load;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_OUT) && out_free;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dp_cmd.op  = OP_NONE;
    dp_cmd.idx = cnt[SLOT_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.op = OP_LATCH;
          case (cmd)
            CMD_TICK:  state_next = S_RD_A;
            CMD_EVENT: state_next = S_EV_START;
            CMD_WRITE: state_next = S_WR;
            default:   state_next = S_SLOT;
          endcase
        end
      end
      S_RD_A: begin
        dp_cmd.op  = OP_RD_A;
        state_next = S_RD_S;
      end
      S_RD_S: begin
        dp_cmd.op  = OP_RD_S;
        state_next = S_MUL_S;
      end
      S_MUL_S: begin
        dp_cmd.op  = OP_MUL_S;
        state_next = S_ACC;
      end
      S_ACC: begin
        dp_cmd.op  = OP_ACC;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          dp_cmd.op  = OP_TICK_END;
          state_next = S_IDLE;
        end
      end
      S_WR: begin
        dp_cmd.op  = OP_WRITE;
        state_next = S_IDLE;
      end
      S_SLOT: begin
        dp_cmd.op  = OP_SLOT;
        state_next = S_IDLE;
      end
      S_EV_START: begin
        dp_cmd.op  = OP_EV_START;
        cnt_next   = '0;
        state_next = S_EV_SUM;
      end
      S_EV_SUM: begin
        dp_cmd.op = OP_EV_SUM;
        if (cnt == CNT_W'(SEEK_SLOTS - 1)) begin
          cnt_next   = '0;
          state_next = S_EV_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EV_CHECK: begin
        state_next = dp_status.total_zero ? S_IDLE : S_EV_DIV;
      end
      S_EV_DIV: begin
        dp_cmd.op = OP_DIV;
        if (cnt == CNT_W'(RND_W - 1)) begin
          cnt_next   = '0;
          state_next = S_EV_PICK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EV_PICK: begin
        dp_cmd.op = OP_PICK;
        if (cnt == CNT_W'(SEEK_SLOTS - 1)) begin
          cnt_next   = '0;
          state_next = S_EV_APPLY;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EV_APPLY: begin
        dp_cmd.op  = OP_APPLY;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DNSP_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE) && !out_valid, "reset left work pending")
  `DNSP_ASSERT(a_accept_leaves_idle, (in_valid && !in_stall) |=> (state != S_IDLE), "accepted transaction not started")
  `DNSP_ASSERT(a_tick_gives_result, out_load |=> out_valid, "finished tick produced no result")
  `DNSP_ASSERT(a_walk_in_range, ((state == S_EV_SUM) || (state == S_EV_PICK)) |-> (cnt < CNT_W'(SEEK_SLOTS)), "slot walk out of range")

endmodule

`default_nettype wire

// ===== rtl/disk_noise_sample_player_top.sv =====
// Top level of the drive-noise sample player.
// Depends on dnsp_pkg, dnsp_ctrl and dnsp_datapath.
//
// Usage: one input channel (in_valid/in_stall) carries commands: tick, disk I/O
// event, sample word write and seek slot write. Only a tick produces an output
// transaction on sample_out (out_valid/out_stall); the other commands produce none.
// The block works on one transaction at a time and stalls its input meanwhile.
// A tick steps through the states S_RD_A, S_RD_S, S_MUL_S, S_ACC and S_OUT before
// its result is registered and the block is idle again: two reads through the
// single read port of the sample memory and one shared multiplier set that sequence.
// A word or slot write passes through S_WR or S_SLOT. An I/O event runs
// a walk over the nine seek slots, a 15-step remainder of the random number
// by the total weight, and a second slot walk for the pick.
// The result sits in an output register; if the receiver stalls, a following
// tick waits at its last step until that register is free, so no result is lost.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data while
// the block is idle. Synchronous reset clears all control state, seek slots,
// voice positions and configuration (gain returns to about 0.2); the sample
// memory holds whatever it held and must be written before it is played.
`timescale 1ns / 1ps
`default_nettype none

module disk_noise_sample_player_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dnsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dnsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       cmd,
  input  logic [15:0]                      address,
  input  logic signed [15:0]               word_value,
  input  logic [3:0]                       slot_index,
  input  logic [16:0]                      slot_length,
  input  logic [14:0]                      random_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [16:0]               sample_out
);
  import dnsp_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  dnsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  dnsp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .address      (address),
    .word_value   (word_value),
    .slot_index   (slot_index),
    .slot_length  (slot_length),
    .random_value (random_value),
    .dp_cmd       (dp_cmd),
    .dp_status    (dp_status),
    .sample_out   (sample_out)
  );

endmodule

`default_nettype wire

// ===== dv/disk_noise_sample_player_top_tb.sv =====
// Self-checking testbench for the drive-noise sample player top level.
// Depends on dnsp_pkg and disk_noise_sample_player_top; predicts every mixed sample.
`timescale 1ns / 1ps

module disk_noise_sample_player_top_tb;
  import dnsp_pkg::*;

  // An index that names no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [15:0] word_value;
    logic [3:0]  slot_index;
    logic [16:0] slot_length;
    logic [14:0] random_value;
  } noise_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [15:0] address = '0;
  logic signed [15:0] word_value = '0;
  logic [3:0] slot_index = '0;
  logic [16:0] slot_length = '0;
  logic [14:0] random_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] sample_out;

  disk_noise_sample_player_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: a shadow of the block's memory, slots, voices and registers.
  logic signed [15:0] shadow_mem [0:MEM_WORDS-1];
  logic [15:0] slot_start_sh [SEEK_SLOTS];
  logic [16:0] slot_len_sh [SEEK_SLOTS];
  logic [16:0] up_pos, spin_pos, seek_pos, seek_len;
  logic [15:0] seek_start;
  logic en_r, loop_r;
  logic [15:0] up_start_r, spin_start_r, gain_r;
  logic [16:0] up_len_r, spin_len_r;

  noise_cmd_t pending_cmds[$];
  logic signed [16:0] expected_samples[$];
  int errors = 0;
  int cycles = 0;
  int ticks_checked = 0;
  int events_sent = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;
  bit hold_sender = 1'b0;

  function automatic longint voice_word(logic [15:0] base, logic [16:0] pos);
    logic [15:0] a;
    a = base + pos[15:0];
    return longint'(shadow_mem[a]);
  endfunction

  function automatic logic signed [16:0] mix_tick();
    longint g, acc;
    g = (gain_r > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_r);
    acc = 0;
    if (up_len_r != 0 && {15'd0, up_pos} + 32'd1 < {15'd0, up_len_r}) begin
      acc += voice_word(up_start_r, up_pos) * g;
      up_pos = up_pos + 17'd1;
    end else if (spin_len_r != 0 &&
                 ({15'd0, spin_pos} + 32'd1 < {15'd0, spin_len_r} || loop_r)) begin
      acc += voice_word(spin_start_r, spin_pos) * g;
      spin_pos = spin_pos + 17'd1;
      if (spin_pos >= spin_len_r && loop_r) spin_pos = '0;
    end
    if (seek_len != 0 && {15'd0, seek_pos} + 32'd1 < {15'd0, seek_len}) begin
      acc += voice_word(seek_start, seek_pos) * g;
      seek_pos = seek_pos + 17'd1;
    end
    if (seek_len != 0 && seek_pos >= seek_len) seek_len = '0;
    return 17'(acc >>> 15);
  endfunction

  function automatic void handle_event(logic [14:0] rnd);
    int total, acc, r, pick;
    total = 0;
    acc = 0;
    pick = -1;
    if (!loop_r && !(spin_len_r == 0 || {15'd0, spin_pos} + 32'd1 < {15'd0, spin_len_r}))
      spin_pos = '0;
    for (int i = 0; i < SEEK_SLOTS; i++)
      if (slot_len_sh[i] != 0) total += SLOT_WEIGHT_BASE - i;
    if (total == 0) return;
    r = int'(rnd) % total;
    for (int i = 0; i < SEEK_SLOTS; i++) begin
      if (slot_len_sh[i] != 0) begin
        acc += SLOT_WEIGHT_BASE - i;
        if (r < acc && pick < 0) pick = i;
      end
    end
    if (pick < 0) return;
    if (seek_len != 0 && {15'd0, seek_pos} + 32'd1 < {15'd0, seek_len}) return;
    seek_start = slot_start_sh[pick];
    seek_len = slot_len_sh[pick];
    seek_pos = '0;
  endfunction

  function automatic void predict_cmd(noise_cmd_t c);
    case (c.cmd)
      CMD_TICK: expected_samples.insert(expected_samples.size(), en_r ? mix_tick() : 17'sd0);
      CMD_EVENT: if (en_r) handle_event(c.random_value);
      CMD_WRITE: shadow_mem[c.address] = c.word_value;
      default: begin
        if (c.slot_index < SEEK_SLOTS) begin
          slot_start_sh[c.slot_index] = c.address;
          slot_len_sh[c.slot_index] = c.slot_length;
        end
      end
    endcase
  endfunction

  // Driver: a transaction is taken at an edge with valid high and stall low.
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && !hold_sender &&
            (quiet_sender || $urandom_range(99) >= 11)) begin
          noise_cmd_t c;
          c = pending_cmds.pop_front();
          predict_cmd(c);
          if (c.cmd == CMD_EVENT) events_sent <= events_sent + 1;
          in_valid <= 1'b1;
          cmd <= c.cmd;
          address <= c.address;
          word_value <= c.word_value;
          slot_index <= c.slot_index;
          slot_length <= c.slot_length;
          random_value <= c.random_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= quiet_receiver ? 1'b0 : ($urandom_range(99) < 11);
    end
  end

  // Monitor: each output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no result expected, actual %0d", sample_out);
        errors <= errors + 1;
      end else begin
        logic signed [16:0] want;
        want = expected_samples.pop_front();
        ticks_checked <= ticks_checked + 1;
        if (sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, sample_out);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("disk_noise_sample_player_top_tb failed");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] c, logic [15:0] a, logic [15:0] w,
                           logic [3:0] s, logic [16:0] l, logic [14:0] r);
    noise_cmd_t t;
    t.cmd = c;
    t.address = a;
    t.word_value = w;
    t.slot_index = s;
    t.slot_length = l;
    t.random_value = r;
    pending_cmds.insert(pending_cmds.size(), t);
  endtask

  // Waits until every queued transaction is in and every result is out,
  // then lets the longest event run out before the block is touched again.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_NOISE_ENABLE: en_r = val[0];
      REG_SPIN_LOOP: loop_r = val[0];
      REG_SPIN_UP_START: up_start_r = val[15:0];
      REG_SPIN_UP_LENGTH: up_len_r = val;
      REG_SPIN_START: spin_start_r = val[15:0];
      REG_SPIN_LENGTH: spin_len_r = val;
      REG_VOICE_GAIN: gain_r = val[15:0];
      default: ;
    endcase
  endtask

  // Random content stays inside a 512-word window that is written in full
  // first. Start addresses keep 64 words clear of the window's end, more than
  // any voice position reaches, so no voice ever reads a word never written.
  function automatic logic [15:0] win_addr();
    return 16'hFF00 + 16'($urandom_range(447));
  endfunction

  function automatic logic [16:0] short_len();
    return ($urandom_range(9) == 0) ? 17'd0 : 17'($urandom_range(1, 40));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(99);
      if (k < 60)
        queue_cmd(CMD_TICK, 16'($urandom), 16'($urandom), 4'($urandom), 17'($urandom),
                  15'($urandom));
      else if (k < 78)
        queue_cmd(CMD_EVENT, 16'($urandom), 16'($urandom), 4'($urandom), 17'($urandom),
                  15'($urandom));
      else if (k < 90)
        queue_cmd(CMD_WRITE, win_addr(), 16'($urandom), 4'($urandom), 17'($urandom),
                  15'($urandom));
      else
        queue_cmd(CMD_SLOT, win_addr(), 16'($urandom), 4'($urandom_range(15)),
                  short_len(), 15'($urandom));
    end
  endtask

  task automatic voice_regs(bit loop, logic [15:0] g);
    write_reg(REG_SPIN_LOOP, loop);
    write_reg(REG_SPIN_UP_START, win_addr());
    write_reg(REG_SPIN_UP_LENGTH, short_len());
    write_reg(REG_SPIN_START, win_addr());
    write_reg(REG_SPIN_LENGTH, short_len());
    write_reg(REG_VOICE_GAIN, g);
  endtask

  initial begin
    en_r = 1'b0; loop_r = 1'b0; up_start_r = '0; spin_start_r = '0;
    up_len_r = '0; spin_len_r = '0; gain_r = GAIN_RESET;
    up_pos = '0; spin_pos = '0; seek_pos = '0; seek_len = '0; seek_start = '0;
    for (int i = 0; i < SEEK_SLOTS; i++) begin
      slot_start_sh[i] = '0;
      slot_len_sh[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: silence while disabled, extreme words at the top of memory,
    // the wrap of start plus position past the last address, out-of-range slots,
    // an event with every slot empty, and one-shot end and restart.
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    queue_cmd(CMD_TICK, 16'h0, 16'h0, 4'h0, 17'h0, 15'h0);
    queue_cmd(CMD_EVENT, 16'h0, 16'h0, 4'h0, 17'h0, 15'h7FFF);
    for (int a = 0; a < 512; a++)
      queue_cmd(CMD_WRITE, 16'hFF00 + 16'(a), (a % 3 == 0) ? 16'h8000 :
                (a % 3 == 1) ? 16'h7FFF : 16'($urandom), 4'h0, 17'h0, 15'h0);
    for (int a = 0; a < 256; a++)
      queue_cmd(CMD_WRITE, 16'(a), 16'($urandom), 4'hF, 17'h1FFFF, 15'h0);
    queue_cmd(CMD_SLOT, 16'hFFFF, 16'h0, 4'd15, 17'h1FFFF, 15'h0);
    queue_cmd(CMD_SLOT, 16'hFFFF, 16'h0, 4'd9, 17'd3, 15'h0);
    drain();
    write_reg(REG_NOISE_ENABLE, 1'b1);
    write_reg(REG_SPIN_LOOP, 1'b0);
    write_reg(REG_SPIN_UP_START, 16'hFFFE);
    write_reg(REG_SPIN_UP_LENGTH, 17'd4);
    write_reg(REG_SPIN_START, 16'hFFFC);
    write_reg(REG_SPIN_LENGTH, 17'd3);
    write_reg(REG_VOICE_GAIN, GAIN_MAX);
    queue_cmd(CMD_EVENT, 16'h0, 16'h0, 4'h0, 17'h0, 15'h0);
    for (int i = 0; i < 7; i++) queue_cmd(CMD_TICK, 16'h0, 16'h0, 4'h0, 17'h0, 15'h0);
    queue_cmd(CMD_SLOT, 16'hFFF0, 16'h0, 4'd0, 17'd1, 15'h0);
    queue_cmd(CMD_SLOT, 16'hFFF8, 16'h0, 4'd8, 17'd12, 15'h0);
    queue_cmd(CMD_EVENT, 16'h0, 16'h0, 4'h0, 17'h0, 15'h7FFF);
    queue_cmd(CMD_TICK, 16'h0, 16'h0, 4'h0, 17'h0, 15'h0);
    queue_cmd(CMD_EVENT, 16'h0, 16'h0, 4'h0, 17'h0, 15'd10);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_TICK, 16'h0, 16'h0, 4'h0, 17'h0, 15'h0);
    drain();

    // Random phases across loop modes and gains, extremes included.
    // Gain above 1.0 in unsigned Q1.15 saturates and must read as full scale.
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      voice_regs(ph[0], (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF :
                 (ph == 2) ? GAIN_MAX : 16'($urandom));
      if (ph == 3) write_reg(REG_NONE, 17'h1FFFF);
      write_reg(REG_NOISE_ENABLE, (ph != 4));
      quiet_sender = (ph == 2);
      quiet_receiver = (ph == 2);
      random_phase(180);
      if (ph == 1) begin
        // Sender holds off until the block has delivered every result.
        while (pending_cmds.size() > 90) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_samples.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    write_reg(REG_SPIN_UP_LENGTH, 17'h10000);
    write_reg(REG_SPIN_LENGTH, 17'h10000);
    write_reg(REG_NOISE_ENABLE, 1'b0);
    drain();

    $display("Checked %0d ticks against predictions; %0d I/O events were sent.",
             ticks_checked, events_sent);
    $display("Covered disabled play, one-shot and looped spin, gain extremes and seeks.");
    if (errors == 0) begin
      $display("disk_noise_sample_player_top_tb passed");
    end else begin
      $display("disk_noise_sample_player_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dnsp_pkg.sv
rtl/dnsp_datapath.sv
rtl/dnsp_ctrl.sv
rtl/disk_noise_sample_player_top.sv
dv/disk_noise_sample_player_top_tb.sv
